>>> rtl/vcth_pkg.sv
// Shared types and constants for the veto coincidence time histogram.
package vcth_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_HIT   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_VETO_OFFSET = 3'd0,
        CFG_GAIN        = 3'd1,
        CFG_E_OFFSET    = 3'd2,
        CFG_E_LIMIT     = 3'd3,
        CFG_GOLD_LO     = 3'd4,
        CFG_GOLD_HI     = 3'd5,
        CFG_NEUT_LO     = 3'd6,
        CFG_NEUT_HI     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        event_id;
        logic [23:0]        energy_raw;
        logic signed [31:0] hit_time;
        logic [1:0]         hist_select;
        logic [5:0]         bin_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [10:0] matched_all;
        logic [10:0] matched_good;
        logic [1:0]  window_hit;
        logic        status;
    } t_out_item;

    // Register reset values.
    localparam logic signed [15:0] RST_VETO_OFFSET = 16'sd24;
    localparam logic [15:0]        RST_GAIN        = 16'd445;
    localparam logic signed [15:0] RST_E_OFFSET    = 16'sd100;
    localparam logic [23:0]        RST_E_LIMIT     = 24'd800000;
    localparam logic signed [31:0] RST_GOLD_LO     = -32'sd240;
    localparam logic signed [31:0] RST_GOLD_HI     = 32'sd240;
    localparam logic signed [31:0] RST_NEUT_LO     = 32'sd800;
    localparam logic signed [31:0] RST_NEUT_HI     = 32'sd1600;

    // Histogram spans, 1/8 ns.
    localparam int GOLD_LO   = -400;
    localparam int GOLD_HI   = 4000;
    localparam int NEUT_LO   = -4000;
    localparam int NEUT_HI   = 4000;
    localparam int GOLD_SPAN = GOLD_HI - GOLD_LO;
    localparam int NEUT_SPAN = NEUT_HI - NEUT_LO;
    localparam int SPAN_W    = $clog2((GOLD_SPAN > NEUT_SPAN) ? GOLD_SPAN : NEUT_SPAN);
    // Reciprocal fraction bits; must exceed SPAN_W.
    localparam int FRAC_W    = 24;

endpackage

>>> rtl/vcth_stream_if.sv
// Valid/ready stream channel carrying one item.
interface vcth_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/vcth_hist.sv
// Histogram counter memory with per-entry valid bits for instant clear.
module vcth_hist #(
    parameter int DEPTH = 208,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data
);
    logic [31:0] mem [DEPTH];
    logic        r_valid [DEPTH];
    logic [31:0] r_data;
    logic        r_dv;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_dv <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_dv <= r_valid[i_rd_addr];
            end
        end
    end

    // never-written counters read as zero
    assign o_rd_data = r_dv ? r_data : 32'd0;
endmodule

>>> rtl/veto_coincidence_time_histogram_unit.sv
// Veto coincidence time-difference histogram unit, top level.
// A detector hit that passes no window skips the veto table scan; each match adds
//   a bin computation and histogram update.
// Throughput: one item at a time; a hit is bounded by the veto table scan,
//   one entry per cycle through the table's single read port, pausing while a match is binned.
// Reset (synchronous, active low): registers to defaults, table empty, histograms zero.
module veto_coincidence_time_histogram_unit #(
    parameter int VETO_DEPTH = 1024,
    parameter int NUM_BINS   = 50
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [31:0]                         i_cfg_wdata,
    vcth_stream_if.sink                         i_in,
    vcth_stream_if.source                       o_out
);
    import vcth_pkg::*;

    localparam int AW     = $clog2(VETO_DEPTH);
    localparam int CW     = $clog2(VETO_DEPTH + 1);
    localparam int STRIDE = NUM_BINS + 2;
    localparam int HD     = 4 * STRIDE;
    localparam int HAW    = $clog2(HD);
    localparam int BNW    = $clog2(NUM_BINS + 2);
    localparam int VW     = SPAN_W;
    localparam int RW     = FRAC_W + BNW;
    localparam int MW     = VW + RW;
    localparam int VNW    = VW + BNW;
    // floor(NUM_BINS * 2^FRAC_W / span): quotient estimate is exact or one low
    localparam logic [RW-1:0] RECIP_G = RW'((longint'(NUM_BINS) << FRAC_W) / GOLD_SPAN);
    localparam logic [RW-1:0] RECIP_N = RW'((longint'(NUM_BINS) << FRAC_W) / NEUT_SPAN);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_LOAD  = 16'h0002,
        S_LOAD2 = 16'h0004,
        S_CAL   = 16'h0008,
        S_WIN   = 16'h0010,
        S_SCAN  = 16'h0020,
        S_BIN0  = 16'h0040,
        S_BIN1  = 16'h0080,
        S_BIN2  = 16'h0100,
        S_BIN3  = 16'h0200,
        S_HRD   = 16'h0400,
        S_HWR   = 16'h0800,
        S_RD    = 16'h1000,
        S_RD2   = 16'h2000,
        S_CLR   = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state;

    // configuration
    logic signed [15:0] r_veto_off;
    logic [15:0]        r_gain;
    logic signed [15:0] r_e_off;
    logic [23:0]        r_e_lim;
    logic signed [31:0] r_gwl, r_gwh, r_nwl, r_nwh;

    // captured item
    logic [31:0]        r_id;
    logic [23:0]        r_raw;
    logic signed [31:0] r_t;
    logic [1:0]         r_sel;
    logic [5:0]         r_bidx;

    // veto table
    logic [31:0]        m_ids   [VETO_DEPTH];
    logic signed [31:0] m_times [VETO_DEPTH];
    logic               m_rep   [VETO_DEPTH];
    logic [CW-1:0]      r_count;
    logic [31:0]        r_last_id;
    logic [AW-1:0]      r_widx;

    // scan
    logic [CW-1:0]      r_k;
    logic               r_pend;
    logic [31:0]        r_q_id;
    logic signed [31:0] r_q_time;
    logic               r_q_rep;

    // per-hit and per-match work
    logic [39:0]        r_prod;
    logic               r_g, r_nw;
    logic signed [32:0] r_d;
    logic               r_good;
    logic               r_wsel;   // 0 gold, 1 neutron
    logic               r_hgood;  // 0 all-histogram, 1 good-histogram
    logic [VW-1:0]      r_v;
    logic [MW-1:0]      r_mul;
    logic [VNW-1:0]     r_vn;
    logic [BNW-1:0]     r_q0;
    logic [BNW-1:0]     r_bin;

    // results
    logic [CW-1:0]      r_m_all, r_m_good;
    logic [31:0]        r_bin_count;
    logic               r_status;
    logic               r_ovalid;
    t_out_item          r_opay;

    // combinational
    logic               accept;
    logic               match;
    logic               scan_rd;
    logic signed [32:0] vsum;
    logic signed [31:0] vsat;
    logic               rep_now;
    logic signed [36:0] energy;
    logic               ecut, g_pass, n_pass;
    logic signed [33:0] x_lo, x_hi, x_rel;
    logic [VNW-1:0]     span_n, rem;
    logic [RW-1:0]      recip;
    logic               out_free;
    logic               h_rd_en, h_wr_en, h_clr;
    logic [HAW-1:0]     h_addr;
    logic [31:0]        h_rdata, h_wdata;
    logic [1:0]         h_sel;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_ovalid || o_out.ready;

    // veto time plus offset, clamped to 32 bits signed
    assign vsum = 33'(r_t) + 33'(r_veto_off);
    always_comb begin
        if (vsum > 33'sd2147483647) begin
            vsat = 32'sh7FFF_FFFF;
        end else if (vsum < -33'sd2147483648) begin
            vsat = 32'sh8000_0000;
        end else begin
            vsat = 32'(vsum);
        end
    end
    assign rep_now = (r_count != '0) && (r_last_id == r_id);

    // calibration and window tests
    assign energy = signed'({2'b00, r_prod[39:5]}) + 37'(r_e_off);
    assign ecut   = energy < signed'({13'd0, r_e_lim});
    assign g_pass = ecut && (r_t > r_gwl) && (r_t < r_gwh);
    assign n_pass = ecut && (r_t > r_nwl) && (r_t < r_nwh);

    assign match   = r_pend && (r_q_id == r_id);
    assign scan_rd = (r_state == S_SCAN) && !match && (r_k < r_count);

    // bin computation for the current window
    always_comb begin
        if (r_wsel) begin
            x_lo   = 34'(NEUT_LO);
            x_hi   = 34'(NEUT_HI);
            span_n = VNW'(NEUT_SPAN);
            recip  = RECIP_N;
        end else begin
            x_lo   = 34'(GOLD_LO);
            x_hi   = 34'(GOLD_HI);
            span_n = VNW'(GOLD_SPAN);
            recip  = RECIP_G;
        end
    end
    assign x_rel = 34'(r_d) - x_lo;
    assign rem   = r_vn - VNW'(r_q0) * span_n;

    // histogram port
    assign h_sel   = {r_wsel, r_hgood};
    assign h_addr  = (r_state == S_RD)
                   ? HAW'(int'(r_sel) * STRIDE + int'(r_bidx))
                   : HAW'(int'(h_sel) * STRIDE + int'(r_bin));
    assign h_rd_en = (r_state == S_HRD)
                   || ((r_state == S_RD) && (int'(r_bidx) < STRIDE));
    assign h_wr_en = (r_state == S_HWR);
    assign h_wdata = (h_rdata == 32'hFFFF_FFFF) ? h_rdata : h_rdata + 32'd1;
    assign h_clr   = (r_state == S_CLR);

    vcth_hist #(
        .DEPTH (HD)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (h_clr),
        .i_rd_en   (h_rd_en),
        .i_rd_addr (h_addr),
        .o_rd_data (h_rdata),
        .i_wr_en   (h_wr_en),
        .i_wr_addr (h_addr),
        .i_wr_data (h_wdata)
    );

    // veto table storage
    always_ff @(posedge i_clk) begin
        if ((r_state == S_LOAD) && (r_count < CW'(VETO_DEPTH))) begin
            m_ids[r_count[AW-1:0]]   <= r_id;
            m_times[r_count[AW-1:0]] <= vsat;
            m_rep[r_count[AW-1:0]]   <= rep_now;
        end else if (r_state == S_LOAD2) begin
            m_rep[r_widx] <= 1'b1;
        end
        if (scan_rd) begin
            r_q_id   <= m_ids[r_k[AW-1:0]];
            r_q_time <= m_times[r_k[AW-1:0]];
            r_q_rep  <= m_rep[r_k[AW-1:0]];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_veto_off <= RST_VETO_OFFSET;
            r_gain     <= RST_GAIN;
            r_e_off    <= RST_E_OFFSET;
            r_e_lim    <= RST_E_LIMIT;
            r_gwl      <= RST_GOLD_LO;
            r_gwh      <= RST_GOLD_HI;
            r_nwl      <= RST_NEUT_LO;
            r_nwh      <= RST_NEUT_HI;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_VETO_OFFSET: r_veto_off <= i_cfg_wdata[15:0];
                CFG_GAIN:        r_gain     <= i_cfg_wdata[15:0];
                CFG_E_OFFSET:    r_e_off    <= i_cfg_wdata[15:0];
                CFG_E_LIMIT:     r_e_lim    <= i_cfg_wdata[23:0];
                CFG_GOLD_LO:     r_gwl      <= i_cfg_wdata;
                CFG_GOLD_HI:     r_gwh      <= i_cfg_wdata;
                CFG_NEUT_LO:     r_nwl      <= i_cfg_wdata;
                CFG_NEUT_HI:     r_nwh      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id   <= i_in.payload.event_id;
            r_raw  <= i_in.payload.energy_raw;
            r_t    <= i_in.payload.hit_time;
            r_sel  <= i_in.payload.hist_select;
            r_bidx <= i_in.payload.bin_index;
        end
        if (r_state == S_CAL) begin
            r_prod <= 40'(r_raw) * 40'(r_gain);
        end
        if (r_state == S_LOAD) begin
            r_widx    <= AW'(r_count - CW'(1));
            r_last_id <= r_id;
        end
        if ((r_state == S_SCAN) && match) begin
            r_d    <= 33'(r_q_time) - 33'(r_t);
            r_good <= !r_q_rep;
        end
        if (r_state == S_BIN0) begin
            if (x_rel < 34'sd0) begin
                r_bin <= '0;
            end else if (34'(r_d) >= x_hi) begin
                r_bin <= BNW'(NUM_BINS + 1);
            end
            r_v <= VW'(x_rel);
        end
        if (r_state == S_BIN1) begin
            r_mul <= MW'(r_v) * MW'(recip);
        end
        if (r_state == S_BIN2) begin
            r_q0 <= BNW'(r_mul >> FRAC_W);
            r_vn <= VNW'(r_v) * VNW'(NUM_BINS);
        end
        if (r_state == S_BIN3) begin
            // correct the reciprocal estimate by one when the remainder spills
            r_bin <= (rem >= span_n) ? r_q0 + BNW'(2) : r_q0 + BNW'(1);
        end
        if (r_state == S_RD2) begin
            r_bin_count <= h_rdata;
        end else if (accept) begin
            r_bin_count <= '0;
        end
        if (r_state == S_DONE && out_free) begin
            r_opay.bin_count    <= r_bin_count;
            r_opay.matched_all  <= 11'(r_m_all);
            r_opay.matched_good <= 11'(r_m_good);
            r_opay.window_hit   <= {r_nw, r_g};
            r_opay.status       <= r_status;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_pend   <= 1'b0;
            r_m_all  <= '0;
            r_m_good <= '0;
            r_g      <= 1'b0;
            r_nw     <= 1'b0;
            r_status <= 1'b0;
            r_wsel   <= 1'b0;
            r_hgood  <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_m_all  <= '0;
                        r_m_good <= '0;
                        r_g      <= 1'b0;
                        r_nw     <= 1'b0;
                        r_status <= 1'b0;
                        unique case (t_op'(i_in.payload.op))
                            OP_LOAD:  r_state <= S_LOAD;
                            OP_HIT:   r_state <= S_CAL;
                            OP_READ:  r_state <= S_RD;
                            OP_CLEAR: r_state <= S_CLR;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_LOAD: begin
                    if (r_count >= CW'(VETO_DEPTH)) begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_count <= r_count + CW'(1);
                        // a repeated id also marks the previous entry
                        r_state <= rep_now ? S_LOAD2 : S_DONE;
                    end
                end
                S_LOAD2: r_state <= S_DONE;
                S_CAL:   r_state <= S_WIN;
                S_WIN: begin
                    r_g    <= g_pass;
                    r_nw   <= n_pass;
                    r_k    <= '0;
                    r_pend <= 1'b0;
                    r_state <= (g_pass || n_pass) ? S_SCAN : S_DONE;
                end
                S_SCAN: begin
                    if (match) begin
                        r_pend   <= 1'b0;
                        r_m_all  <= r_m_all + CW'(1);
                        r_m_good <= r_q_rep ? r_m_good : r_m_good + CW'(1);
                        r_wsel   <= !r_g;
                        r_hgood  <= 1'b0;
                        r_state  <= S_BIN0;
                    end else if (!r_pend && (r_k >= r_count)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pend <= (r_k < r_count);
                        if (r_k < r_count) begin
                            r_k <= r_k + CW'(1);
                        end
                    end
                end
                S_BIN0: begin
                    // under- and overflow skip the divide
                    if ((x_rel < 34'sd0) || (34'(r_d) >= x_hi)) begin
                        r_state <= S_HRD;
                    end else begin
                        r_state <= S_BIN1;
                    end
                end
                S_BIN1: r_state <= S_BIN2;
                S_BIN2: r_state <= S_BIN3;
                S_BIN3: r_state <= S_HRD;
                S_HRD:  r_state <= S_HWR;
                S_HWR: begin
                    if (!r_hgood && r_good) begin
                        r_hgood <= 1'b1;
                        r_state <= S_HRD;
                    end else if (!r_wsel && r_nw) begin
                        r_wsel  <= 1'b1;
                        r_hgood <= 1'b0;
                        r_state <= S_BIN0;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_RD: begin
                    r_state <= (int'(r_bidx) < STRIDE) ? S_RD2 : S_DONE;
                end
                S_RD2: r_state <= S_DONE;
                S_CLR: begin
                    r_count <= '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_opay;

    // table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(VETO_DEPTH))
        else $error("veto count beyond table depth");

    // scan pointer stays inside the filled part of the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_count))
        else $error("scan pointer past veto count");

    // a clear empties the table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> (r_count == '0))
        else $error("table not empty after clear");

    // histogram updates only land on a legal bin
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_wr_en |-> (int'(r_bin) <= NUM_BINS + 1))
        else $error("histogram bin out of range");

endmodule

>>> tb/tb_veto_coincidence_time_histogram_unit.sv
// Self-checking testbench for veto_coincidence_time_histogram_unit.
module tb_veto_coincidence_time_histogram_unit;
    import vcth_pkg::*;

    localparam int N_BINS  = 50;
    localparam int STRIDE  = N_BINS + 2;
    localparam int DEPTH   = 1024;
    localparam int IMAX    = 2147483647;
    localparam int IMIN    = -2147483647 - 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    vcth_stream_if #(.T(t_in_item))  in_if ();
    vcth_stream_if #(.T(t_out_item)) out_if ();

    veto_coincidence_time_histogram_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow of the block's registers and storage.
    logic signed [15:0] sh_veto_offset;
    logic [15:0]        sh_gain;
    logic signed [15:0] sh_e_offset;
    logic [23:0]        sh_e_limit;
    logic signed [31:0] sh_gold_lo, sh_gold_hi, sh_neut_lo, sh_neut_hi;
    logic [31:0]        sh_ids   [DEPTH];
    logic signed [31:0] sh_times [DEPTH];
    logic               sh_rep   [DEPTH];
    int unsigned        sh_count;
    logic [31:0]        sh_hist  [4][STRIDE];

    t_out_item pending_results[$];
    int        n_errors;
    bit        no_gaps;
    int        hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sink side: random back-pressure, always ready when no_gaps is set, or a long counted hold when asked.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else if (no_gaps) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= 35);
            end
        end
    end

    function automatic int unsigned hist_bin(longint x, longint lo, longint hi);
        if (x < lo) return 0;
        if (x >= hi) return N_BINS + 1;
        return int'(((x - lo) * N_BINS) / (hi - lo)) + 1;
    endfunction

    function automatic void bump(int s, int unsigned b);
        if (sh_hist[s][b] != 32'hFFFF_FFFF) sh_hist[s][b]++;
    endfunction

    function automatic void clear_histograms();
        foreach (sh_hist[s, b]) sh_hist[s][b] = '0;
    endfunction

    function automatic void shadow_register(t_cfg_idx idx, logic [31:0] v);
        case (idx)
            CFG_VETO_OFFSET: sh_veto_offset = v[15:0];
            CFG_GAIN:        sh_gain        = v[15:0];
            CFG_E_OFFSET:    sh_e_offset    = v[15:0];
            CFG_E_LIMIT:     sh_e_limit     = v[23:0];
            CFG_GOLD_LO:     sh_gold_lo     = v;
            CFG_GOLD_HI:     sh_gold_hi     = v;
            CFG_NEUT_LO:     sh_neut_lo     = v;
            CFG_NEUT_HI:     sh_neut_hi     = v;
            default: ;
        endcase
    endfunction

    // Expected response of one accepted item; updates the shadow state.
    function automatic t_out_item histogram_response(t_in_item it);
        t_out_item r;
        longint    vt, e, d, t;
        bit        ecut, g, nw, good;
        int unsigned b;
        r = '0;
        t = it.hit_time;
        case (t_op'(it.op))
            OP_LOAD: begin
                if (sh_count >= DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    vt = t + longint'(sh_veto_offset);
                    if (vt > IMAX) vt = IMAX;
                    if (vt < IMIN) vt = IMIN;
                    sh_ids[sh_count]   = it.event_id;
                    sh_times[sh_count] = vt[31:0];
                    sh_rep[sh_count]   = 1'b0;
                    if (sh_count > 0 && sh_ids[sh_count-1] == it.event_id) begin
                        sh_rep[sh_count]   = 1'b1;
                        sh_rep[sh_count-1] = 1'b1;
                    end
                    sh_count++;
                end
            end
            OP_HIT: begin
                e    = longint'((64'(it.energy_raw) * 64'(sh_gain)) >> 5)
                       + longint'(sh_e_offset);
                ecut = e < longint'({8'd0, sh_e_limit});
                g    = ecut && t > sh_gold_lo && t < sh_gold_hi;
                nw   = ecut && t > sh_neut_lo && t < sh_neut_hi;
                r.window_hit = {nw, g};
                if (g || nw) begin
                    for (int k = 0; k < sh_count; k++) begin
                        if (sh_ids[k] == it.event_id) begin
                            d    = longint'(sh_times[k]) - t;
                            good = !sh_rep[k];
                            r.matched_all++;
                            if (good) r.matched_good++;
                            if (g) begin
                                b = hist_bin(d, GOLD_LO, GOLD_HI);
                                bump(0, b);
                                if (good) bump(1, b);
                            end
                            if (nw) begin
                                b = hist_bin(d, NEUT_LO, NEUT_HI);
                                bump(2, b);
                                if (good) bump(3, b);
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                if (it.bin_index < STRIDE)
                    r.bin_count = sh_hist[it.hist_select][it.bin_index];
            end
            default: begin
                sh_count = 0;
                clear_histograms();
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %0h", $time, out_if.payload);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("bin_count", want.bin_count, out_if.payload.bin_count);
                compare_field("matched_all", want.matched_all, out_if.payload.matched_all);
                compare_field("matched_good", want.matched_good, out_if.payload.matched_good);
                compare_field("window_hit", want.window_hit, out_if.payload.window_hit);
                compare_field("status", want.status, out_if.payload.status);
            end
        end
    end

    // Offer one item; returns at the edge where it is accepted.
    task automatic send_item(t_op op, logic [31:0] id, logic [23:0] raw,
                             logic signed [31:0] t, logic [1:0] sel, logic [5:0] bidx);
        t_in_item  it;
        t_out_item expected;
        it = '{op: op, event_id: id, energy_raw: raw, hit_time: t,
               hist_select: sel, bin_index: bidx};
        @(negedge i_clk);
        if (!no_gaps && $urandom_range(0, 99) < 35) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected = histogram_response(it);
        pending_results = {pending_results, expected};
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [31:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_register(idx, v);
    endtask

    task automatic read_bin(int sel, int bidx);
        send_item(OP_READ, $urandom, 24'($urandom), $urandom, sel[1:0], bidx[5:0]);
    endtask

    // Defaults, single-entry table, repeated neighbors, saturation, both windows.
    task automatic test_directed();
        read_bin(0, 0);
        read_bin(3, 63);
        send_item(OP_LOAD, 32'd5, 24'd0, 32'sd0, 2'd0, 6'd0);
        send_item(OP_HIT, 32'd5, 24'd0, 32'sd0, 2'd0, 6'd0);
        read_bin(1, 5);
        send_item(OP_LOAD, 32'd5, 24'hFFFFFF, 32'sd100, 2'd3, 6'd63);
        send_item(OP_LOAD, 32'hFFFF_FFFF, 24'd0, 32'h7FFF_FFFF, 2'd0, 6'd0);
        send_item(OP_HIT, 32'd5, 24'd1000, -32'sd239, 2'd0, 6'd0);
        send_item(OP_HIT, 32'hFFFF_FFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 2'd0, 6'd0);
        send_item(OP_HIT, 32'd0, 24'd0, 32'sd0, 2'd0, 6'd0);
        for (int b = 0; b < 4; b++) read_bin(b, 5);
        read_bin(0, 51);
        read_bin(2, 52);
        write_register(CFG_NEUT_LO, -32'sd1000);
        write_register(CFG_NEUT_HI, 32'sd1000);
        send_item(OP_HIT, 32'd5, 24'd0, 32'sd0, 2'd0, 6'd0);
        write_register(CFG_VETO_OFFSET, 32'hFFFF_8000);
        send_item(OP_LOAD, 32'd7, 24'd0, 32'h8000_0000, 2'd0, 6'd0);
        write_register(CFG_GOLD_LO, 32'h8000_0000);
        send_item(OP_HIT, 32'd7, 24'd0, 32'h8000_0001, 2'd0, 6'd0);
        read_bin(0, 0);
        read_bin(1, 0);
        send_item(OP_CLEAR, 32'd0, 24'd0, 32'sd0, 2'd0, 6'd0);
        read_bin(2, 26);
        send_item(OP_HIT, 32'd5, 24'd0, 32'sd0, 2'd0, 6'd0);
    endtask

    // Sink holds off while the source keeps offering back-to-back items.
    task automatic test_backpressure();
        no_gaps     = 1'b1;
        hold_cycles = 300;
        for (int k = 0; k < 30; k++) begin
            if (k % 3 == 2) send_item(OP_HIT, 32'd9, 24'd0, 32'sd0, 2'd0, 6'd0);
            else if (k % 3 == 1) read_bin($urandom_range(0, 3), $urandom_range(0, 51));
            else send_item(OP_LOAD, 32'd9, 24'd0, $urandom_range(0, 400), 2'd0, 6'd0);
        end
        no_gaps = 1'b0;
    endtask

    function automatic logic [31:0] pick16();
        case ($urandom_range(0, 3))
            0: return 32'h0000_8000;
            1: return 32'h0000_7FFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config(int profile, int t0);
        logic [31:0] lo, hi;
        write_register(CFG_VETO_OFFSET, pick16());
        write_register(CFG_E_OFFSET, pick16());
        write_register(CFG_GAIN, (profile == 0) ? 32'd0 : (profile == 1) ? 32'hFFFF
                                 : $urandom_range(1, 2000));
        write_register(CFG_E_LIMIT, (profile == 3) ? 32'd0 : (profile == 1) ? 32'hFF_FFFF
                                    : $urandom_range(1000, 24'hFF_FFFF));
        for (int w = 0; w < 2; w++) begin
            if (profile == 1 || profile == 4) begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end else begin
                lo = t0 - $urandom_range(0, 3000);
                hi = t0 + $urandom_range(0, 3000);
            end
            write_register(w ? CFG_NEUT_LO : CFG_GOLD_LO, lo);
            write_register(w ? CFG_NEUT_HI : CFG_GOLD_HI, hi);
        end
    endtask

    // Phases of random traffic: mostly veto loads and hits on a small id pool
    // around one time reference, plus bin reads, clears and raw noise.
    task automatic test_random();
        int          t0, roll;
        logic [31:0] id_base, id;
        for (int ph = 0; ph < 6; ph++) begin
            t0 = (ph == 4) ? IMAX - 2000 : (ph == 5) ? IMIN + 2000
                 : int'($urandom_range(0, 200000)) - 100000;
            id_base = $urandom;
            random_config((ph == 2) ? 3 : ph % 5, t0);
            for (int k = 0; k < 88; k++) begin
                roll = $urandom_range(0, 99);
                id   = ($urandom_range(0, 9) == 0) ? $urandom : id_base + $urandom_range(0, 5);
                if (roll < 30 && sh_count >= 48) begin
                    send_item(OP_CLEAR, $urandom, 24'($urandom), $urandom, 2'd0, 6'd0);
                end else if (roll < 30) begin
                    send_item(OP_LOAD, id, 24'($urandom), t0 + $urandom_range(0, 5000) - 1000,
                              2'($urandom), 6'($urandom));
                end else if (roll < 60) begin
                    send_item(OP_HIT, id,
                              24'(($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 4000)),
                              t0 + $urandom_range(0, 3000) - 1500,
                              2'($urandom), 6'($urandom));
                end else if (roll < 90) begin
                    read_bin($urandom_range(0, 3),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(52, 63)
                                                         : $urandom_range(0, 51));
                end else if (roll < 93) begin
                    send_item(OP_CLEAR, $urandom, 24'($urandom), $urandom,
                              2'($urandom), 6'($urandom));
                end else begin
                    send_item(($urandom_range(0, 1) || sh_count >= 48) ? OP_READ : OP_HIT,
                              $urandom, 24'($urandom), $urandom,
                              2'($urandom), 6'($urandom));
                end
            end
        end
    endtask

    initial begin
        n_errors      = 0;
        no_gaps       = 1'b0;
        hold_cycles   = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_VETO_OFFSET;
        i_cfg_wdata   = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        sh_veto_offset = RST_VETO_OFFSET;
        sh_gain        = RST_GAIN;
        sh_e_offset    = RST_E_OFFSET;
        sh_e_limit     = RST_E_LIMIT;
        sh_gold_lo     = RST_GOLD_LO;
        sh_gold_hi     = RST_GOLD_HI;
        sh_neut_lo     = RST_NEUT_LO;
        sh_neut_hi     = RST_NEUT_HI;
        sh_count       = 0;
        clear_histograms();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("veto_coincidence_time_histogram_unit verification clean");
        else
            $display("veto_coincidence_time_histogram_unit verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20000000;
        $display("veto_coincidence_time_histogram_unit verification failed");
        $finish;
    end

endmodule
